// ===== sv/lsc_pkg.sv =====
package lsc_pkg;

	localparam int PT_W      = 24;
	localparam int NRM_W     = 16;
	localparam int GRID_W    = 16;
	localparam int CELL_W    = 25;
	localparam int QUO_W     = 24;
	localparam int NUM_W     = 37;
	localparam int DIV_W     = 28;
	localparam int PROD_W    = 42;
	localparam int DIFF_W    = 20;
	localparam int SQ_W      = 36;
	localparam int DIST_W    = 38;
	localparam int MAX_CAND  = 8;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 4;
	localparam int NUDGE_DEN = 3200;

	localparam logic [2:0] CMD_BLOCK = 3'd0;
	localparam logic [2:0] CMD_WALL  = 3'd1;
	localparam logic [2:0] CMD_FLOOR = 3'd2;
	localparam logic [2:0] CMD_POST  = 3'd3;
	localparam logic [2:0] CMD_BEAM  = 3'd4;

	localparam logic [1:0] KIND_VOLUME = 2'd0;
	localparam logic [1:0] KIND_FACE   = 2'd1;
	localparam logic [1:0] KIND_EDGE   = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// off[0] x, off[1] y, off[2] z: step from the base cell
	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] axis;
		logic [2:0] off;
	} cand_t;

	typedef struct packed {
		logic [2:0]                           cmd;
		logic [CNT_W-1:0]                     count;
		logic [2:0][CELL_W-1:0]               base;
		logic [MAX_CAND-1:0][IDX_W-1:0]       order;
	} job_t;

	function automatic logic [CNT_W-1:0] count_of(input logic [2:0] cmd);
		logic [CNT_W-1:0] n;
		case (cmd)
			CMD_BLOCK: n = CNT_W'(1);
			CMD_WALL:  n = CNT_W'(4);
			CMD_FLOOR: n = CNT_W'(2);
			CMD_POST:  n = CNT_W'(4);
			CMD_BEAM:  n = CNT_W'(8);
			default:   n = '0;
		endcase
		return n;
	endfunction

	// Candidate in generation order for a slot kind
	function automatic cand_t cand_of(input logic [2:0] cmd, input logic [IDX_W-1:0] idx);
		cand_t c;
		c = '0;
		case (cmd)
			CMD_BLOCK: begin
				c.kind = KIND_VOLUME;
				c.axis = AXIS_X;
			end
			CMD_WALL: begin
				c.kind = KIND_FACE;
				if (idx[1]) begin
					c.axis   = AXIS_Z;
					c.off[2] = idx[0];
				end else begin
					c.axis   = AXIS_X;
					c.off[0] = idx[0];
				end
			end
			CMD_FLOOR: begin
				c.kind   = KIND_FACE;
				c.axis   = AXIS_Y;
				c.off[1] = idx[0];
			end
			CMD_POST: begin
				c.kind   = KIND_EDGE;
				c.axis   = AXIS_Y;
				c.off[2] = idx[1];
				c.off[0] = idx[0];
			end
			CMD_BEAM: begin
				c.kind = KIND_EDGE;
				if (idx[2]) begin
					c.axis   = AXIS_Z;
					c.off[0] = idx[1];
					c.off[1] = idx[0];
				end else begin
					c.axis   = AXIS_X;
					c.off[1] = idx[1];
					c.off[2] = idx[0];
				end
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/lsc_front.sv =====
module lsc_front #(
	parameter int DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [2:0]                           in_cmd,
	input  logic [2:0][lsc_pkg::PT_W-1:0]        in_point,
	input  logic [2:0][lsc_pkg::NRM_W-1:0]       in_normal,
	input  logic [lsc_pkg::GRID_W-1:0]           grid,
	input  logic                                 pop,
	output logic                                 push,
	output lsc_pkg::job_t                        push_job
);

	localparam int BITS_PER_STEP = 3;
	localparam int STEPS         = lsc_pkg::QUO_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(STEPS);
	localparam int CR_W          = $clog2(DEPTH + 1);

	localparam int PT_W   = lsc_pkg::PT_W;
	localparam int DIV_W  = lsc_pkg::DIV_W;
	localparam int QUO_W  = lsc_pkg::QUO_W;
	localparam int NUM_W  = lsc_pkg::NUM_W;
	localparam int CELL_W = lsc_pkg::CELL_W;
	localparam int PROD_W = lsc_pkg::PROD_W;
	localparam int DIFF_W = lsc_pkg::DIFF_W;
	localparam int SQ_W   = lsc_pkg::SQ_W;
	localparam int DIST_W = lsc_pkg::DIST_W;
	localparam int NC     = lsc_pkg::MAX_CAND;
	localparam int IDX_W  = lsc_pkg::IDX_W;
	localparam int GRID_W_FIX = lsc_pkg::GRID_W;

	// one restoring step: shift in the next numerator bit, subtract if it fits
	function automatic logic [DIV_W+QUO_W-1:0] div_step(input logic [DIV_W-1:0] rem,
			input logic [QUO_W-1:0] num, input logic [DIV_W-1:0] den);
		logic [DIV_W:0]   r2;
		logic [DIV_W-1:0] rn;
		logic             qb;
		r2 = {rem, num[QUO_W-1]};
		if (r2 >= {1'b0, den}) begin
			rn = DIV_W'(r2 - {1'b0, den});
			qb = 1'b1;
		end else begin
			rn = r2[DIV_W-1:0];
			qb = 1'b0;
		end
		return {rn, num[QUO_W-2:0], qb};
	endfunction

	logic                          hold_v_q;
	logic [2:0]                    hold_cmd_q;
	logic [2:0][PT_W-1:0]          hold_p_q;
	logic [2:0][lsc_pkg::NRM_W-1:0] hold_n_q;

	logic                          busy_q;
	logic [STEP_W-1:0]             step_q;
	logic [CR_W-1:0]               credit_q;
	logic [2:0]                    div_cmd_q;
	logic [2:0][PT_W-1:0]          div_p_q;
	logic [2:0]                    sign_q;
	logic [2:0][DIV_W-1:0]         rem_q;
	logic [2:0][QUO_W-1:0]         num_q;

	logic                          accept, launch, done;
	logic [GRID_W_FIX-1:0]         g_eff;
	logic [DIV_W-1:0]              den;
	logic signed [NUM_W-1:0]       nm [3];
	logic [NUM_W-1:0]              um [3];
	logic [2:0][DIV_W-1:0]         rem_nxt;
	logic [2:0][QUO_W-1:0]         num_nxt;
	logic [DIV_W+QUO_W-1:0]        st;

	assign g_eff    = (grid == '0) ? GRID_W_FIX'(1) : grid;
	assign den      = DIV_W'(g_eff) * DIV_W'(lsc_pkg::NUDGE_DEN);
	// start the next division in the cycle the current one finishes
	assign launch   = hold_v_q && (!busy_q || done) && (credit_q != '0);
	assign in_ready = !hold_v_q || launch;
	assign accept   = in_valid && in_ready;
	assign done     = busy_q && (step_q == STEP_W'(STEPS - 1));

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nm[a] = NUM_W'($signed(hold_p_q[a])) * NUM_W'(lsc_pkg::NUDGE_DEN)
				+ NUM_W'($signed(hold_n_q[a]));
			um[a] = nm[a] ^ {NUM_W{nm[a][NUM_W-1]}};
		end
	end

	always_comb begin
		st = '0;
		for (int a = 0; a < 3; a++) begin
			rem_nxt[a] = rem_q[a];
			num_nxt[a] = num_q[a];
			for (int b = 0; b < BITS_PER_STEP; b++) begin
				st         = div_step(rem_nxt[a], num_nxt[a], den);
				rem_nxt[a] = st[DIV_W+QUO_W-1:QUO_W];
				num_nxt[a] = st[QUO_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			busy_q   <= 1'b0;
			step_q   <= '0;
			credit_q <= CR_W'(DEPTH);
		end else begin
			if (accept) begin
				hold_v_q <= (lsc_pkg::count_of(in_cmd) != '0);
			end else if (launch) begin
				hold_v_q <= 1'b0;
			end
			if (launch) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (done) begin
					busy_q <= 1'b0;
				end
			end
			credit_q <= credit_q - CR_W'(launch) + CR_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_cmd_q <= in_cmd;
			hold_p_q   <= in_point;
			hold_n_q   <= in_normal;
		end
		if (launch) begin
			div_cmd_q <= hold_cmd_q;
			div_p_q   <= hold_p_q;
			for (int a = 0; a < 3; a++) begin
				sign_q[a] <= nm[a][NUM_W-1];
				rem_q[a]  <= DIV_W'(um[a][NUM_W-3:QUO_W]);
				num_q[a]  <= um[a][QUO_W-1:0];
			end
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			num_q <= num_nxt;
		end
	end

	// result pipeline: floor, scale, offsets, squares, distances, ranks
	logic                             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [2:0]                       cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	logic [2:0][CELL_W-1:0]           base_s1, base_s2, base_s3, base_s4, base_s5, base_s6;
	logic [2:0][PT_W-1:0]             p_s1, p_s2;
	logic signed [PROD_W-1:0]         prod_s2 [3];
	logic [DIFF_W-1:0]                diff_s3 [3][3];
	logic [SQ_W-1:0]                  sq_s4 [3][3];
	logic [DIST_W-1:0]                dist_s5 [NC];
	logic [IDX_W-1:0]                 rank_s6 [NC];

	logic signed [PROD_W:0]           t3 [3];
	logic [DIFF_W-1:0]                d0 [3];
	logic signed [2*DIFF_W-1:0]       sqf [3][3];
	logic [DIST_W-1:0]                dsum [NC];
	lsc_pkg::cand_t                   cd;
	logic                             on_plane;
	logic [IDX_W-1:0]                 rank_c [NC];
	logic                             ahead;
	logic [lsc_pkg::CNT_W-1:0]        cnt5, cnt6;

	assign cnt5 = lsc_pkg::count_of(cmd_s5);
	assign cnt6 = lsc_pkg::count_of(cmd_s6);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			t3[a] = $signed({prod_s2[a], 1'b0})
				- $signed({{(PROD_W - PT_W){p_s2[a][PT_W-1]}}, p_s2[a], 1'b0});
			d0[a] = t3[a][DIFF_W-1:0];
			for (int v = 0; v < 3; v++) begin
				sqf[a][v] = $signed(diff_s3[a][v]) * $signed(diff_s3[a][v]);
			end
		end
	end

	always_comb begin
		cd       = '0;
		on_plane = 1'b0;
		for (int i = 0; i < NC; i++) begin
			cd      = lsc_pkg::cand_of(cmd_s4, IDX_W'(i));
			dsum[i] = '0;
			for (int a = 0; a < 3; a++) begin
				case (cd.kind)
					lsc_pkg::KIND_FACE: on_plane = (cd.axis == 2'(a));
					lsc_pkg::KIND_EDGE: on_plane = (cd.axis != 2'(a));
					default:            on_plane = 1'b0;
				endcase
				if (!on_plane) begin
					dsum[i] = dsum[i] + DIST_W'(sq_s4[a][2]);
				end else if (cd.off[a]) begin
					dsum[i] = dsum[i] + DIST_W'(sq_s4[a][1]);
				end else begin
					dsum[i] = dsum[i] + DIST_W'(sq_s4[a][0]);
				end
			end
		end
	end

	// stable rank: count the valid candidates that go out ahead of this one
	always_comb begin
		ahead = 1'b0;
		for (int i = 0; i < NC; i++) begin
			rank_c[i] = '0;
			for (int j = 0; j < NC; j++) begin
				ahead = (j != i) && (lsc_pkg::CNT_W'(j) < cnt5)
					&& ((dist_s5[j] < dist_s5[i]) || ((dist_s5[j] == dist_s5[i]) && (j < i)));
				rank_c[i] = rank_c[i] + IDX_W'(ahead);
			end
		end
	end

	always_comb begin
		push_job.cmd   = cmd_s6;
		push_job.count = cnt6;
		push_job.base  = base_s6;
		for (int k = 0; k < NC; k++) begin
			push_job.order[k] = '0;
			for (int i = 0; i < NC; i++) begin
				if ((lsc_pkg::CNT_W'(i) < cnt6) && (rank_s6[i] == IDX_W'(k))) begin
					push_job.order[k] = push_job.order[k] | IDX_W'(i);
				end
			end
		end
	end

	assign push = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= done;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			base_s1[a] <= {1'b0, num_nxt[a]} ^ {CELL_W{sign_q[a]}};
			prod_s2[a] <= $signed(base_s1[a]) * $signed({1'b0, g_eff});
			diff_s3[a][0] <= d0[a];
			diff_s3[a][1] <= d0[a] + DIFF_W'({g_eff, 1'b0});
			diff_s3[a][2] <= d0[a] + DIFF_W'(g_eff);
			for (int v = 0; v < 3; v++) begin
				sq_s4[a][v] <= sqf[a][v][SQ_W-1:0];
			end
		end
		for (int i = 0; i < NC; i++) begin
			dist_s5[i] <= dsum[i];
			rank_s6[i] <= rank_c[i];
		end
		cmd_s1  <= div_cmd_q;
		p_s1    <= div_p_q;
		cmd_s2  <= cmd_s1;
		p_s2    <= p_s1;
		base_s2 <= base_s1;
		cmd_s3  <= cmd_s2;
		base_s3 <= base_s2;
		cmd_s4  <= cmd_s3;
		base_s4 <= base_s3;
		cmd_s5  <= cmd_s4;
		base_s5 <= base_s4;
		cmd_s6  <= cmd_s5;
		base_s6 <= base_s5;
	end

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CR_W'(DEPTH))
		else $error("queue credit above queue depth");
	a_done_feeds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> v_s1)
		else $error("divider result not taken into the pipeline");
	a_launch_starts: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> (busy_q && (step_q == '0) && !done))
		else $error("divider did not start cleanly");
`endif

endmodule

// ===== sv/lsc_fifo.sv =====
module lsc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lsc_pkg::job_t push_job,
	input  logic          pop,
	output logic          head_valid,
	output lsc_pkg::job_t head_job
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);

	lsc_pkg::job_t    mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((cnt_q < CW'(DEPTH)) || pop))
		else $error("job queue overflow");
`endif

endmodule

// ===== sv/lsc_back.sv =====
module lsc_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  lsc_pkg::job_t                      head_job,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         out_kind,
	output logic [1:0]                         out_axis,
	output logic [2:0][lsc_pkg::CELL_W-1:0]    out_cells,
	output logic                               out_last
);

	localparam int IDX_W  = lsc_pkg::IDX_W;
	localparam int CNT_W  = lsc_pkg::CNT_W;
	localparam int CELL_W = lsc_pkg::CELL_W;

	lsc_pkg::job_t  job_q;
	logic           job_v_q;
	logic [IDX_W-1:0] pos_q;
	logic           emit, is_last;
	lsc_pkg::cand_t cd;

	assign emit    = job_v_q && (!out_valid || out_ready);
	assign is_last = ((CNT_W'(pos_q) + CNT_W'(1)) == job_q.count);
	assign pop     = head_valid && (!job_v_q || (emit && is_last));
	assign cd      = lsc_pkg::cand_of(job_q.cmd, job_q.order[pos_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q   <= 1'b0;
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (pop) begin
				job_v_q <= 1'b1;
				pos_q   <= '0;
			end else if (emit) begin
				pos_q <= pos_q + IDX_W'(1);
				if (is_last) begin
					job_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (emit) begin
			out_kind <= cd.kind;
			out_axis <= cd.axis;
			out_last <= is_last;
			for (int a = 0; a < 3; a++) begin
				out_cells[a] <= job_q.base[a] + CELL_W'(cd.off[a]);
			end
		end
	end

endmodule

// ===== sv/lattice_snap_candidates.sv =====
// Lattice snap candidates. Each request carries a hit point (Q.8, signed,
// 24 bits per axis), a surface normal (Q2.14) and a slot kind on tuser
// (0 block, 1 wall, 2 floor, 3 post, 4 beam; kinds 5 to 7 are taken and
// dropped without output). The point is pushed 0.02 m along the normal and
// floored to a base cell of grid_size (1/256 m units, 0 acts as 1); the block
// then sends the lattice elements of that slot (1, 4, 2, 4 or 8 of them) in
// ascending distance of their centre from the original point, ties in
// generation order, with tlast on the final one. The front part holds one
// request, divides all three axes at once with a divider that retires three
// quotient bits a cycle, then runs a six stage pipeline for scaling,
// squared distances and a stable rank; each request lands as one job in a
// short queue. The back part sends one candidate per cycle, while
// m_axis_tready does not stall it, through a registered output. The divider
// takes the next request in the cycle it finishes the current one, and
// only while the queue has a free slot. Write grid_size only while no
// request is in flight.
module lattice_snap_candidates #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // point_x, point_y, point_z, normal_x, normal_y, normal_z
	input  logic [2:0]   s_axis_tuser,  // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [79:0]  m_axis_tdata,  // cell_x, cell_y, cell_z, zero pad
	output logic [3:0]   m_axis_tuser,  // element_kind, element_axis
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	localparam int PT_W   = lsc_pkg::PT_W;
	localparam int NRM_W  = lsc_pkg::NRM_W;
	localparam int CELL_W = lsc_pkg::CELL_W;

	logic [lsc_pkg::GRID_W-1:0]   grid_q;
	logic [2:0][PT_W-1:0]         point;
	logic [2:0][NRM_W-1:0]        normal;
	logic                         push, pop, head_valid;
	lsc_pkg::job_t                push_job, head_job;
	logic [1:0]                   kind, axis;
	logic [2:0][CELL_W-1:0]       cells;

	// the register takes a write every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= 16'd256;
		end else if (cfg_valid) begin
			grid_q <= cfg_data;
		end
	end

	// unpack the request: three points, then three normals, x first
	assign point  = s_axis_tdata[3*PT_W-1:0];
	assign normal = s_axis_tdata[3*PT_W+3*NRM_W-1:3*PT_W];

	lsc_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_point  (point),
		.in_normal (normal),
		.grid      (grid_q),
		.pop       (pop),
		.push      (push),
		.push_job  (push_job)
	);

	// jobs wait here; the front only launches a division when a slot is free
	lsc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (kind),
		.out_axis   (axis),
		.out_cells  (cells),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {{(80 - 3*CELL_W){1'b0}}, cells};
	assign m_axis_tuser = {axis, kind};

endmodule
